FILE: src/multi_queue_ring_buffer_assert.svh
// ----------------------------------------------------------------------------
// Multi-queue ring buffer assertion macros
// Short forms for the clocked, reset-qualified properties used by the block.
// ----------------------------------------------------------------------------
`ifndef MULTI_QUEUE_RING_BUFFER_ASSERT_SVH
`define MULTI_QUEUE_RING_BUFFER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MQRB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MQRB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/mqrb_pkg.sv
// ----------------------------------------------------------------------------
// Multi-queue ring buffer package
// Shared constants, operation and status codes, and transfer types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mqrb_pkg;

    localparam int NUM_QUEUES_DEF  = 16;
    localparam int QUEUE_DEPTH_DEF = 128;
    localparam int ITEM_WIDTH_DEF  = 32;

    // Operation codes.
    localparam logic [1:0] OP_ACTIVATE = 2'd0;
    localparam logic [1:0] OP_ENQUEUE  = 2'd1;
    localparam logic [1:0] OP_DEQUEUE  = 2'd2;
    localparam logic [1:0] OP_PEEK     = 2'd3;

    // Status codes.
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_INVALID    = 3'd1;
    localparam logic [2:0] ST_FULL       = 3'd2;
    localparam logic [2:0] ST_EMPTY      = 3'd3;
    localparam logic [2:0] ST_ALL_ACTIVE = 3'd4;

    typedef struct packed {
        logic [1:0]         op;
        logic [3:0]         queue_index;
        logic signed [31:0] item;
    } request_t;

    typedef struct packed {
        logic signed [31:0] head_value;
        logic signed [31:0] tail_value;
        logic [2:0]         status;
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the request
        logic exec;      // decide, update pointers, write or start the head read
        logic cap_head;  // capture head data, start the tail read when peeking
        logic cap_tail;  // capture tail data
    } cmd_t;

    // Status from the datapath to the controller, meaningful during exec.
    typedef struct packed {
        logic read_needed;
        logic peek;
    } sts_t;

endpackage

FILE: src/mqrb_datapath.sv
// ----------------------------------------------------------------------------
// Multi-queue ring buffer datapath
// Queue pointers, empty marks, shared item store and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "multi_queue_ring_buffer_assert.svh"

module mqrb_datapath #(
    parameter int NUM_QUEUES  = mqrb_pkg::NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH = mqrb_pkg::QUEUE_DEPTH_DEF,
    parameter int ITEM_WIDTH  = mqrb_pkg::ITEM_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  mqrb_pkg::request_t request,
    input  mqrb_pkg::cmd_t     cmd,
    output mqrb_pkg::sts_t     sts,
    output mqrb_pkg::result_t  result
);

    localparam int QW   = $clog2(QUEUE_DEPTH);
    localparam int QIW  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int CW   = $clog2(NUM_QUEUES + 1);
    localparam int CMPW = (CW > 4) ? CW : 4;
    localparam int SIZE = NUM_QUEUES * QUEUE_DEPTH;
    localparam int AW   = (SIZE > 1) ? $clog2(SIZE) : 1;
    localparam logic [QW-1:0] PTR_LAST = QW'(QUEUE_DEPTH - 1);
    localparam logic [AW-1:0] DEPTH_A  = AW'(QUEUE_DEPTH);

    mqrb_pkg::request_t req_reg;
    mqrb_pkg::result_t  res_reg;

    logic [QW-1:0]         head_reg [NUM_QUEUES];
    logic [QW-1:0]         tail_reg [NUM_QUEUES];
    logic [NUM_QUEUES-1:0] empty_reg;
    logic [CW-1:0]         count_reg;

    logic [ITEM_WIDTH-1:0] mem [SIZE];
    logic [ITEM_WIDTH-1:0] rd_data_reg;
    logic [QW-1:0]         tail_ptr_reg;

    logic [QIW-1:0] q_idx;
    logic [QIW-1:0] act_idx;
    logic           q_valid;
    logic           all_active;
    logic [QW-1:0]  head_cur;
    logic [QW-1:0]  tail_cur;
    logic [QW-1:0]  tail_inc;
    logic [QW-1:0]  head_inc;
    logic           q_empty;
    logic [2:0]     status_next;
    logic           wr_en;
    logic [QW-1:0]  wr_ptr;
    logic           rd_en;
    logic [AW-1:0]  rd_addr;
    logic [AW-1:0]  q_base;

    assign q_idx      = QIW'(req_reg.queue_index);
    assign act_idx    = QIW'(count_reg);
    assign q_valid    = CMPW'(req_reg.queue_index) < CMPW'(count_reg);
    assign all_active = (count_reg == CW'(NUM_QUEUES));
    assign head_cur   = head_reg[q_idx];
    assign tail_cur   = tail_reg[q_idx];
    assign q_empty    = empty_reg[q_idx];
    assign tail_inc   = (tail_cur == PTR_LAST) ? '0 : tail_cur + QW'(1);
    assign head_inc   = (head_cur == PTR_LAST) ? '0 : head_cur + QW'(1);
    assign q_base     = AW'(q_idx) * DEPTH_A;

    // Decision for the request held in req_reg.
    always_comb
    begin
        status_next = mqrb_pkg::ST_OK;
        if (req_reg.op == mqrb_pkg::OP_ACTIVATE)
        begin
            if (all_active)
                status_next = mqrb_pkg::ST_ALL_ACTIVE;
        end
        else if (!q_valid)
            status_next = mqrb_pkg::ST_INVALID;
        else if (req_reg.op == mqrb_pkg::OP_ENQUEUE)
        begin
            if (!q_empty && tail_inc == head_cur)
                status_next = mqrb_pkg::ST_FULL;
        end
        else if (q_empty)
            status_next = mqrb_pkg::ST_EMPTY;
    end

    assign sts.peek        = (req_reg.op == mqrb_pkg::OP_PEEK);
    assign sts.read_needed = (status_next == mqrb_pkg::ST_OK) &&
                             (req_reg.op == mqrb_pkg::OP_DEQUEUE ||
                              req_reg.op == mqrb_pkg::OP_PEEK);

    assign wr_en  = cmd.exec && req_reg.op == mqrb_pkg::OP_ENQUEUE &&
                    status_next == mqrb_pkg::ST_OK;
    assign wr_ptr = q_empty ? '0 : tail_inc;

    // Head read at exec, tail read when capturing the head of a peek.
    assign rd_en   = (cmd.exec && sts.read_needed) || (cmd.cap_head && sts.peek);
    assign rd_addr = q_base + AW'(cmd.cap_head ? tail_ptr_reg : head_cur);

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[q_base + AW'(wr_ptr)] <= ITEM_WIDTH'($unsigned(req_reg.item));
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // Request and result registers (payload, no reset).
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            req_reg <= request;
        if (cmd.exec)
        begin
            tail_ptr_reg       <= tail_cur;
            res_reg.status     <= status_next;
            res_reg.head_value <= '0;
            res_reg.tail_value <= '0;
        end
        if (cmd.cap_head)
            res_reg.head_value <= 32'($signed(rd_data_reg));
        if (cmd.cap_tail)
            res_reg.tail_value <= 32'($signed(rd_data_reg));
    end

    // Queue control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
            end
            empty_reg <= '1;
            count_reg <= '0;
        end
        else if (cmd.exec && status_next == mqrb_pkg::ST_OK)
        begin
            case (req_reg.op)
                mqrb_pkg::OP_ACTIVATE:
                begin
                    head_reg[act_idx]  <= '0;
                    tail_reg[act_idx]  <= '0;
                    empty_reg[act_idx] <= 1'b1;
                    count_reg          <= count_reg + CW'(1);
                end
                mqrb_pkg::OP_ENQUEUE:
                begin
                    if (q_empty)
                    begin
                        head_reg[q_idx]  <= '0;
                        tail_reg[q_idx]  <= '0;
                        empty_reg[q_idx] <= 1'b0;
                    end
                    else
                        tail_reg[q_idx] <= tail_inc;
                end
                mqrb_pkg::OP_DEQUEUE:
                begin
                    if (head_cur == tail_cur)
                    begin
                        head_reg[q_idx]  <= '0;
                        tail_reg[q_idx]  <= '0;
                        empty_reg[q_idx] <= 1'b1;
                    end
                    else
                        head_reg[q_idx] <= head_inc;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign result = res_reg;

    `MQRB_ASSERT_SAME(a_count_bounded, 1'b1, count_reg <= CW'(NUM_QUEUES),
        "active queue count exceeds the number of queues")
    `MQRB_ASSERT_SAME(a_no_rd_wr_clash, wr_en, !rd_en,
        "item store read and write in the same cycle")
    `MQRB_ASSERT_NEXT(a_enqueue_marks, wr_en, !empty_reg[$past(q_idx)],
        "queue still marked empty after an enqueue")

endmodule

FILE: src/mqrb_controller.sv
// ----------------------------------------------------------------------------
// Multi-queue ring buffer controller
// Sequences one request through decision, store reads and the result strobe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "multi_queue_ring_buffer_assert.svh"

module mqrb_controller (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  mqrb_pkg::sts_t sts,
    output mqrb_pkg::cmd_t cmd,
    output logic           busy,
    output logic           done
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_EXEC    = 3'd1;
    localparam logic [2:0] S_RD_HEAD = 3'd2;
    localparam logic [2:0] S_RD_TAIL = 3'd3;
    localparam logic [2:0] S_RESP    = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:    if (start) state_next = S_EXEC;
            S_EXEC:    state_next = sts.read_needed ? S_RD_HEAD : S_RESP;
            S_RD_HEAD: state_next = sts.peek ? S_RD_TAIL : S_RESP;
            S_RD_TAIL: state_next = S_RESP;
            S_RESP:    state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = (state_reg == S_RESP);
    assign cmd.load     = (state_reg == S_IDLE) && start;
    assign cmd.exec     = (state_reg == S_EXEC);
    assign cmd.cap_head = (state_reg == S_RD_HEAD);
    assign cmd.cap_tail = (state_reg == S_RD_TAIL);

    `MQRB_ASSERT_NEXT(a_start_runs, start && !busy, busy && !done,
        "accepted request did not start work")
    `MQRB_ASSERT_NEXT(a_done_frees, done, !busy,
        "controller stayed busy after the result strobe")
    `MQRB_ASSERT_NEXT(a_tail_after_head, cmd.cap_tail, done,
        "tail capture not followed by the result strobe")

endmodule

FILE: src/multi_queue_ring_buffer.sv
// ----------------------------------------------------------------------------
// Multi-queue ring buffer
// Several circular FIFOs sharing one item store, driven by single requests.
// ----------------------------------------------------------------------------
// A request is taken when start is high while busy is low, and exactly one
// result follows: done is high for a single cycle with head_value,
// tail_value and status on result, and the receiver cannot hold it back, so
// it must take the transfer in that cycle. After the accepting edge the
// request passes through the decision state, then the head read (dequeue
// and peek only), then the tail read (peek only) and then the done state;
// activate, enqueue and any request that ends in an error status skip both
// reads. Busy falls in the cycle after done, and the next request can be
// taken once busy is low. This order is set by the single read port of the
// shared item store, whose read data is registered: the head item and, for
// a peek, the tail item are fetched one after the other. No clearing pass
// is needed after reset, because only entries that have been written are
// ever read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multi_queue_ring_buffer #(
    parameter int NUM_QUEUES  = mqrb_pkg::NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH = mqrb_pkg::QUEUE_DEPTH_DEF,
    parameter int ITEM_WIDTH  = mqrb_pkg::ITEM_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  mqrb_pkg::request_t request,
    output logic               done,
    output mqrb_pkg::result_t  result
);

    // The controller only sees commands and status; all queue state lives
    // in the datapath.
    mqrb_pkg::cmd_t cmd;
    mqrb_pkg::sts_t sts;

    mqrb_controller u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // The datapath holds the pointers, empty marks, the shared store and the
    // result registers that are presented while done is high.
    mqrb_datapath #(
        .NUM_QUEUES  (NUM_QUEUES),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ITEM_WIDTH  (ITEM_WIDTH)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .sts     (sts),
        .result  (result)
    );

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// Multi-queue ring buffer testbench
// Drives request transfers into the block with bursty timing and checks every
// result against a cycle-free prediction of the queue store, pointers and
// empty marks, held in a small scoreboard class.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam int NQ          = mqrb_pkg::NUM_QUEUES_DEF;
    localparam int QD          = mqrb_pkg::QUEUE_DEPTH_DEF;
    localparam int IW          = mqrb_pkg::ITEM_WIDTH_DEF;
    localparam int ITEM_SHIFT  = 32 - IW;
    localparam int ITEM_TARGET = 1700;

    // ------------------------------------------------------------------------
    // Scoreboard. note_request works out the one result that an accepted
    // request will produce and queues it; check_result compares each result
    // transfer with the oldest result still outstanding.
    // ------------------------------------------------------------------------
    class ring_queue_scoreboard;
        logic [31:0]        item_mem [NQ*QD];
        int unsigned        head_ptr [NQ];
        int unsigned        tail_ptr [NQ];
        bit                 is_empty [NQ];
        int unsigned        live_queues;
        mqrb_pkg::result_t  pending_results [$];
        int                 errors;

        function new();
            for (int i = 0; i < NQ; i++)
            begin
                head_ptr[i] = 0;
                tail_ptr[i] = 0;
                is_empty[i] = 1'b1;
            end
            foreach (item_mem[i])
                item_mem[i] = '0;
            live_queues = 0;
            errors      = 0;
        endfunction

        // Stored items keep only their low IW bits and come back sign-extended.
        function logic signed [31:0] widen(logic [31:0] v);
            return $signed(v << ITEM_SHIFT) >>> ITEM_SHIFT;
        endfunction

        function void note_request(mqrb_pkg::request_t r);
            mqrb_pkg::result_t want;
            int unsigned       q;
            int unsigned       next_tail;
            want        = '0;
            want.status = mqrb_pkg::ST_OK;
            q           = r.queue_index;
            if (r.op == mqrb_pkg::OP_ACTIVATE)
            begin
                if (live_queues >= NQ)
                    want.status = mqrb_pkg::ST_ALL_ACTIVE;
                else
                begin
                    head_ptr[live_queues] = 0;
                    tail_ptr[live_queues] = 0;
                    is_empty[live_queues] = 1'b1;
                    live_queues++;
                end
            end
            else if (q >= live_queues)
                want.status = mqrb_pkg::ST_INVALID;
            else if (r.op == mqrb_pkg::OP_ENQUEUE)
            begin
                if (is_empty[q])
                begin
                    head_ptr[q]       = 0;
                    tail_ptr[q]       = 0;
                    is_empty[q]       = 1'b0;
                    item_mem[q * QD]  = r.item;
                end
                else
                begin
                    next_tail = (tail_ptr[q] + 1) % QD;
                    if (next_tail == head_ptr[q])
                        want.status = mqrb_pkg::ST_FULL;
                    else
                    begin
                        tail_ptr[q]                  = next_tail;
                        item_mem[q * QD + next_tail] = r.item;
                    end
                end
            end
            else if (is_empty[q])
                want.status = mqrb_pkg::ST_EMPTY;
            else if (r.op == mqrb_pkg::OP_DEQUEUE)
            begin
                want.head_value = widen(item_mem[q * QD + head_ptr[q]]);
                if (head_ptr[q] == tail_ptr[q])
                begin
                    head_ptr[q] = 0;
                    tail_ptr[q] = 0;
                    is_empty[q] = 1'b1;
                end
                else
                    head_ptr[q] = (head_ptr[q] + 1) % QD;
            end
            else
            begin
                want.head_value = widen(item_mem[q * QD + head_ptr[q]]);
                want.tail_value = widen(item_mem[q * QD + tail_ptr[q]]);
            end
            pending_results.push_back(want);
        endfunction

        function void check_result(mqrb_pkg::result_t got);
            mqrb_pkg::result_t want;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %p", $time, got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.head_value !== want.head_value)
            begin
                $display("%0t: head_value expected %0d, actual %0d",
                         $time, want.head_value, got.head_value);
                errors++;
            end
            if (got.tail_value !== want.tail_value)
            begin
                $display("%0t: tail_value expected %0d, actual %0d",
                         $time, want.tail_value, got.tail_value);
                errors++;
            end
            if (got.status !== want.status)
            begin
                $display("%0t: status expected %0d, actual %0d",
                         $time, want.status, got.status);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block itself. Every input has a known value from
    // time zero; reset is held low at the start and never asserted again.
    // ------------------------------------------------------------------------
    logic               clk     = 1'b0;
    logic               rst_n   = 1'b0;
    logic               start   = 1'b0;
    mqrb_pkg::request_t request = '0;
    logic               busy;
    logic               done;
    mqrb_pkg::result_t  result;

    ring_queue_scoreboard sb = new();

    int burst_left = 0;
    int issued     = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    multi_queue_ring_buffer u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    // ------------------------------------------------------------------------
    // Monitor. Both sides are sampled at the rising edge, before any update
    // scheduled at that edge has landed, so the values seen are the ones the
    // block itself acts on. A request transfer takes place where start is high
    // and busy is low; a result transfer wherever done is high, since the
    // receiver has no means of holding it back.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done === 1'b1)
                sb.check_result(result);
            if (start === 1'b1 && busy === 1'b0)
                sb.note_request(request);
        end
    end

    // ------------------------------------------------------------------------
    // Driver helpers.
    // ------------------------------------------------------------------------
    function automatic mqrb_pkg::request_t make_req(logic [1:0] op, logic [3:0] q,
                                                    logic [31:0] item);
        mqrb_pkg::request_t r;
        r.op          = op;
        r.queue_index = q;
        r.item        = item;
        return r;
    endfunction

    // Mostly random values, with the extremes of the signed range mixed in.
    function automatic logic [31:0] pick_item();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Start stays high until the transfer edge; the caller then either offers
    // the next request straight away or drops start for a gap.
    task automatic issue(mqrb_pkg::request_t r);
        start   <= 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    // A gap between bursts: start low and the request bus filled with noise,
    // which the block must ignore.
    task automatic pause(int cycles);
        if (cycles > 0)
        begin
            start   <= 1'b0;
            request <= make_req(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), $urandom);
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Sends one request as part of a burst. Once a burst runs out a gap of
    // random length follows, sometimes none at all, so that back-to-back
    // stretches also occur and gaps end at every point of the block's work.
    task automatic send(mqrb_pkg::request_t r);
        if (burst_left == 0)
        begin
            pause(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        issued++;
        issue(r);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------
    initial
    begin
        int         kind;
        int         runs;
        int         roll;
        logic [3:0] q;
        logic [1:0] op;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. With no queue active, every queue number is invalid.
        send(make_req(mqrb_pkg::OP_ENQUEUE, 4'd15, 32'hFFFF_FFFF));
        send(make_req(mqrb_pkg::OP_PEEK,    4'd0,  $urandom));
        send(make_req(mqrb_pkg::OP_DEQUEUE, 4'd0,  $urandom));
        // First queue up: underflow and a peek at an empty queue.
        send(make_req(mqrb_pkg::OP_ACTIVATE, 4'd9, $urandom));
        send(make_req(mqrb_pkg::OP_DEQUEUE,  4'd0, $urandom));
        send(make_req(mqrb_pkg::OP_PEEK,     4'd0, $urandom));
        // Both signed extremes through the store, head and tail peeked, then
        // the items taken out in turn and one dequeue too many.
        send(make_req(mqrb_pkg::OP_ENQUEUE, 4'd0, 32'h7FFF_FFFF));
        send(make_req(mqrb_pkg::OP_ENQUEUE, 4'd0, 32'h8000_0000));
        send(make_req(mqrb_pkg::OP_PEEK,    4'd0, $urandom));
        send(make_req(mqrb_pkg::OP_DEQUEUE, 4'd0, $urandom));
        send(make_req(mqrb_pkg::OP_DEQUEUE, 4'd0, $urandom));
        send(make_req(mqrb_pkg::OP_DEQUEUE, 4'd0, $urandom));
        // Queue 1 is not active yet.
        send(make_req(mqrb_pkg::OP_ENQUEUE, 4'd1, $urandom));
        // Bring up every remaining queue, then ask for one more.
        for (int i = 1; i < NQ; i++)
            send(make_req(mqrb_pkg::OP_ACTIVATE, 4'($urandom_range(0, 15)), $urandom));
        send(make_req(mqrb_pkg::OP_ACTIVATE, 4'd15, $urandom));

        // Random part, built from runs. Long fill runs on one queue reach the
        // overflow case, drain runs reach underflow, and alternating them moves
        // the pointers round the ring so that they wrap.
        while (issued < ITEM_TARGET)
        begin
            kind = $urandom_range(0, 9);
            q    = 4'($urandom_range(0, 15));
            if (kind <= 2)
            begin
                runs = $urandom_range(1, 140);
                repeat (runs)
                begin
                    op = ($urandom_range(0, 9) == 0) ? mqrb_pkg::OP_PEEK : mqrb_pkg::OP_ENQUEUE;
                    send(make_req(op, q, pick_item()));
                end
            end
            else if (kind <= 4)
            begin
                runs = $urandom_range(1, 140);
                repeat (runs)
                begin
                    op = ($urandom_range(0, 9) == 0) ? mqrb_pkg::OP_PEEK : mqrb_pkg::OP_DEQUEUE;
                    send(make_req(op, q, $urandom));
                end
            end
            else if (kind <= 8)
            begin
                runs = $urandom_range(1, 30);
                repeat (runs)
                begin
                    roll = $urandom_range(0, 99);
                    q    = 4'($urandom_range(0, 15));
                    if (roll < 40)
                        send(make_req(mqrb_pkg::OP_ENQUEUE, q, pick_item()));
                    else if (roll < 70)
                        send(make_req(mqrb_pkg::OP_DEQUEUE, q, $urandom));
                    else if (roll < 95)
                        send(make_req(mqrb_pkg::OP_PEEK, q, $urandom));
                    else
                        send(make_req(mqrb_pkg::OP_ACTIVATE, q, $urandom));
                end
            end
            else
            begin
                runs = $urandom_range(1, 10);
                repeat (runs)
                    send(make_req(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                                  $urandom));
            end
        end
        start <= 1'b0;

        // Drain: wait for every outstanding result, then a few more cycles in
        // case the block produces a transfer that nothing asked for.
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog, several times the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+src
src/mqrb_pkg.sv
src/mqrb_datapath.sv
src/mqrb_controller.sv
src/multi_queue_ring_buffer.sv
tb/tb_top.sv
